/* rtl/core/qqmd_pkg.sv */
// Shared constants and control types for the quantized pose decoder.
package qqmd_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CODE_W        = 16;
    localparam int ROT_W         = 22;
    localparam int TR_W          = 16;
    localparam int N_QUAT        = 4;
    localparam int N_TRANS       = 3;
    localparam int N_ROT         = 9;
    localparam int IN_DATA_W     = 112;
    localparam int OUT_DATA_W    = 248;

    localparam logic [CODE_W-1:0] Q_BIAS  = 16'd32766;
    localparam logic [CODE_W-1:0] Q_DIV   = 16'd16383;
    localparam logic [CODE_W-1:0] Q_HALF  = 16'd8191;
    localparam logic [CODE_W-1:0] T_BIAS  = 16'd32768;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } qfix_en_t;

    typedef struct packed {
        logic s1;
        logic s2;
    } rnd_en_t;

endpackage

/* rtl/core/qqmd_qfix.sv */
// Three-stage quaternion code to fixed-point converter (divide by 16383, round).
module qqmd_qfix #(
    parameter int FRAC_BITS = qqmd_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  qqmd_pkg::qfix_en_t            en,
    input  logic [qqmd_pkg::CODE_W-1:0]   code,
    output logic signed [FRAC_BITS+2:0]   q
);

    localparam int MAG_W = qqmd_pkg::CODE_W;
    localparam int M_W   = MAG_W + FRAC_BITS;
    localparam int QE_W  = FRAC_BITS + 3;

    // stage 1: sign and magnitude of code - bias
    logic [MAG_W:0]    diff;
    logic              sign1_reg, sign1_next;
    logic [MAG_W-1:0]  mag1_reg, mag1_next;

    // stage 2: scaled numerator and quotient estimate
    logic [M_W-1:0]    num;
    logic [M_W:0]      acc;
    logic              sign2_reg;
    logic [M_W-1:0]    num2_reg;
    logic [QE_W-1:0]   qe2_reg, qe2_next;

    // stage 3: correct estimate by one, apply sign
    logic [M_W:0]      rem;
    logic [QE_W-1:0]   qmag;
    logic signed [QE_W-1:0] q3_reg, q3_next;

    always_comb
    begin
        diff       = {1'b0, code} - {1'b0, qqmd_pkg::Q_BIAS};
        sign1_next = diff[MAG_W];
        mag1_next  = sign1_next ? MAG_W'(-diff) : diff[MAG_W-1:0];
    end

    // 1/16383 = 2^-14 * (1 + 2^-14 + 2^-28 + ...); estimate is low by at most one
    always_comb
    begin
        num      = {mag1_reg, {FRAC_BITS{1'b0}}} + M_W'(qqmd_pkg::Q_HALF);
        acc      = {1'b0, num} + (M_W+1)'(num >> 14) + (M_W+1)'(num >> 28);
        qe2_next = acc[M_W:14];
    end

    always_comb
    begin
        rem     = {1'b0, num2_reg} - {qe2_reg, 14'b0} + (M_W+1)'(qe2_reg);
        qmag    = qe2_reg + QE_W'(rem >= (M_W+1)'(qqmd_pkg::Q_DIV));
        q3_next = sign2_reg ? -$signed(qmag) : $signed(qmag);
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            sign1_reg <= sign1_next;
            mag1_reg  <= mag1_next;
        end
        if (en.s2)
        begin
            sign2_reg <= sign1_reg;
            num2_reg  <= num;
            qe2_reg   <= qe2_next;
        end
        if (en.s3)
        begin
            q3_reg <= q3_next;
        end
    end

    assign q = q3_reg;

endmodule

/* rtl/core/qqmd_round.sv */
// Two-stage round-half-away and saturate of one matrix entry to 22 bits.
module qqmd_round #(
    parameter int FRAC_BITS = qqmd_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  qqmd_pkg::rnd_en_t                 en,
    input  logic signed [2*FRAC_BITS+5:0]     val,
    output logic signed [qqmd_pkg::ROT_W-1:0] rot
);

    localparam int SW   = 2 * FRAC_BITS + 6;
    localparam int RM_W = SW - FRAC_BITS;
    localparam int XW   = (RM_W + 1 > qqmd_pkg::ROT_W + 1) ? RM_W + 1 : qqmd_pkg::ROT_W + 1;
    localparam logic signed [XW-1:0] SAT_MAX = XW'((64'sd1 <<< (qqmd_pkg::ROT_W - 1)) - 1);
    localparam logic signed [XW-1:0] SAT_MIN = -XW'(64'sd1 <<< (qqmd_pkg::ROT_W - 1));

    logic [SW-1:0]          mag;
    logic [SW-1:0]          mag_rnd;
    logic                   sign_reg, sign_next;
    logic [RM_W-1:0]        rm_reg, rm_next;
    logic signed [XW-1:0]   sv;
    logic signed [qqmd_pkg::ROT_W-1:0] rot_reg, rot_next;

    always_comb
    begin
        sign_next = val[SW-1];
        mag       = sign_next ? SW'(-val) : SW'(val);
        mag_rnd   = mag + (SW'(1) << (FRAC_BITS - 1));
        rm_next   = mag_rnd[SW-1:FRAC_BITS];
    end

    always_comb
    begin
        sv = sign_reg ? -$signed(XW'(rm_reg)) : $signed(XW'(rm_reg));
        priority if (sv > SAT_MAX)
            rot_next = SAT_MAX[qqmd_pkg::ROT_W-1:0];
        else if (sv < SAT_MIN)
            rot_next = SAT_MIN[qqmd_pkg::ROT_W-1:0];
        else
            rot_next = sv[qqmd_pkg::ROT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            sign_reg <= sign_next;
            rm_reg   <= rm_next;
        end
        if (en.s2)
        begin
            rot_reg <= rot_next;
        end
    end

    assign rot = rot_reg;

endmodule

/* rtl/core/quantized_quat_to_matrix_decode.sv */
// Top level: quantized bone pose to 3x3 rotation matrix plus translation.
// Throughput: one beat per cycle while m_tready stays high; a stage takes new data when it
//   is empty or the next stage moves, and tready ripples back through all seven stages in
//   the same cycle.
// Stages: 1-3 quaternion scaling, 4 products, 5 matrix sums, 6-7 rounding and saturation.
// Reset: rst_n (asynchronous, active low) clears the valid bits only.
module quantized_quat_to_matrix_decode #(
    parameter int FRAC_BITS = qqmd_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // quat_w_raw, quat_x_raw, quat_y_raw, quat_z_raw, trans_x_raw, trans_y_raw,
    // trans_z_raw, 16 bits each, from bit 0 up
    input  logic [qqmd_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22
    // (22 bits each), trans_x, trans_y, trans_z (16 bits each), 2 zero pad bits
    output logic [qqmd_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int N_STG = 7;
    localparam int QW    = FRAC_BITS + 3;
    localparam int PW    = 2 * QW;
    localparam int SW    = 2 * FRAC_BITS + 6;
    localparam int CW    = qqmd_pkg::CODE_W;
    localparam int TW    = qqmd_pkg::TR_W;
    localparam int RW    = qqmd_pkg::ROT_W;
    localparam logic signed [SW-1:0] ONE_V = SW'(1) <<< (2 * FRAC_BITS);

    // Per-stage valid bits and ready chain; rdy[N_STG+1] is the sink.
    logic [N_STG:1]   vld_reg;
    logic [N_STG+1:1] rdy;

    always_comb
    begin
        rdy[N_STG+1] = m_tready;
        for (int i = N_STG; i >= 1; i--)
        begin
            rdy[i] = ~vld_reg[i] | rdy[i+1];
        end
    end

    // Shift valid bits forward wherever a stage moves.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[1])
                vld_reg[1] <= s_tvalid;
            for (int i = 2; i <= N_STG; i++)
            begin
                if (rdy[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    assign s_tready = rdy[1];
    assign m_tvalid = vld_reg[N_STG];

    // Quaternion component scaling, stages 1 to 3.
    qqmd_pkg::qfix_en_t qfix_en;
    logic signed [QW-1:0] qv [qqmd_pkg::N_QUAT];

    assign qfix_en = '{s1: rdy[1], s2: rdy[2], s3: rdy[3]};

    for (genvar g = 0; g < qqmd_pkg::N_QUAT; g++)
    begin : g_qfix
        qqmd_qfix #(
            .FRAC_BITS (FRAC_BITS)
        ) u_qfix (
            .clk  (clk),
            .en   (qfix_en),
            .code (s_tdata[g*CW +: CW]),
            .q    (qv[g])
        );
    end

    // Translation needs only the bias removed; carry it alongside the matrix.
    logic [TW-1:0] tr_next [qqmd_pkg::N_TRANS];
    logic [TW-1:0] tr_reg  [1:N_STG][qqmd_pkg::N_TRANS];

    always_comb
    begin
        for (int k = 0; k < qqmd_pkg::N_TRANS; k++)
        begin
            tr_next[k] = s_tdata[(qqmd_pkg::N_QUAT + k)*CW +: CW] - qqmd_pkg::T_BIAS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
            tr_reg[1] <= tr_next;
        for (int i = 2; i <= N_STG; i++)
        begin
            if (rdy[i])
                tr_reg[i] <= tr_reg[i-1];
        end
    end

    // Stage 4: the nine products. qv order is w, x, y, z.
    // prod order: xx, yy, zz, xy, xz, yz, wx, wy, wz
    logic signed [PW-1:0] prod_next [9];
    logic signed [PW-1:0] prod_reg  [9];

    always_comb
    begin
        prod_next[0] = qv[1] * qv[1];
        prod_next[1] = qv[2] * qv[2];
        prod_next[2] = qv[3] * qv[3];
        prod_next[3] = qv[1] * qv[2];
        prod_next[4] = qv[1] * qv[3];
        prod_next[5] = qv[2] * qv[3];
        prod_next[6] = qv[0] * qv[1];
        prod_next[7] = qv[0] * qv[2];
        prod_next[8] = qv[0] * qv[3];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[4])
            prod_reg <= prod_next;
    end

    // Stage 5: matrix entries, still at twice the fraction bits.
    logic signed [SW-1:0] pe [9];
    logic signed [SW-1:0] ent_next [qqmd_pkg::N_ROT];
    logic signed [SW-1:0] ent_reg  [qqmd_pkg::N_ROT];

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            pe[k] = SW'(prod_reg[k]);
        end
        ent_next[0] = ONE_V - ((pe[1] + pe[2]) <<< 1);
        ent_next[1] = (pe[3] - pe[8]) <<< 1;
        ent_next[2] = (pe[4] + pe[7]) <<< 1;
        ent_next[3] = (pe[3] + pe[8]) <<< 1;
        ent_next[4] = ONE_V - ((pe[0] + pe[2]) <<< 1);
        ent_next[5] = (pe[5] - pe[6]) <<< 1;
        ent_next[6] = (pe[4] - pe[7]) <<< 1;
        ent_next[7] = (pe[5] + pe[6]) <<< 1;
        ent_next[8] = ONE_V - ((pe[0] + pe[1]) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[5])
            ent_reg <= ent_next;
    end

    // Stages 6 and 7: round to FRAC_BITS and saturate; stage 7 is the output register.
    qqmd_pkg::rnd_en_t rnd_en;
    logic signed [RW-1:0] rot [qqmd_pkg::N_ROT];

    assign rnd_en = '{s1: rdy[6], s2: rdy[7]};

    for (genvar g = 0; g < qqmd_pkg::N_ROT; g++)
    begin : g_round
        qqmd_round #(
            .FRAC_BITS (FRAC_BITS)
        ) u_round (
            .clk (clk),
            .en  (rnd_en),
            .val (ent_reg[g]),
            .rot (rot[g])
        );
    end

    // Pack the output beat, first field lowest.
    always_comb
    begin
        m_tdata = '0;
        for (int k = 0; k < qqmd_pkg::N_ROT; k++)
        begin
            m_tdata[k*RW +: RW] = rot[k];
        end
        for (int k = 0; k < qqmd_pkg::N_TRANS; k++)
        begin
            m_tdata[qqmd_pkg::N_ROT*RW + k*TW +: TW] = tr_reg[N_STG][k];
        end
    end

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the quantized pose decoder: stream stimulus and scoreboard.
`timescale 1ns / 1ps

typedef logic [qqmd_pkg::IN_DATA_W-1:0]  pose_beat_t;
typedef logic [qqmd_pkg::OUT_DATA_W-1:0] matrix_beat_t;

// Expected-matrix store with its own fixed-point decoder.
class pose_scoreboard;
    localparam int FRAC   = qqmd_pkg::FRAC_BITS_DEF;
    localparam int PAD_LO = qqmd_pkg::N_ROT * qqmd_pkg::ROT_W
                            + qqmd_pkg::N_TRANS * qqmd_pkg::TR_W;

    matrix_beat_t matrices_due[$];
    int           fails;

    function new();
        fails = 0;
    endfunction

    function int pending();
        return matrices_due.size();
    endfunction

    // Scale one quaternion code to FRAC fraction bits, rounded to nearest.
    function longint quat_to_fixed(logic [qqmd_pkg::CODE_W-1:0] code);
        longint bias, divisor, d, mag, r;
        bias    = longint'(qqmd_pkg::Q_BIAS);
        divisor = longint'(qqmd_pkg::Q_DIV);
        d       = longint'(code) - bias;
        mag     = (d < 0) ? -d : d;
        r       = (2 * (mag <<< FRAC) + divisor) / (2 * divisor);
        return (d < 0) ? -r : r;
    endfunction

    // Drop FRAC fraction bits with ties away from zero, then clamp to the entry width.
    function logic [qqmd_pkg::ROT_W-1:0] round_entry(longint v);
        longint mag, r, s, hi, lo;
        hi  = (longint'(1) <<< (qqmd_pkg::ROT_W - 1)) - 1;
        lo  = -(longint'(1) <<< (qqmd_pkg::ROT_W - 1));
        mag = (v < 0) ? -v : v;
        r   = (mag + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        s   = (v < 0) ? -r : r;
        if (s > hi)
            s = hi;
        if (s < lo)
            s = lo;
        return s[qqmd_pkg::ROT_W-1:0];
    endfunction

    function matrix_beat_t decode_pose(pose_beat_t pose);
        longint       qw, qx, qy, qz, unity;
        longint       entry [qqmd_pkg::N_ROT];
        matrix_beat_t mat;
        qw    = quat_to_fixed(pose[0*qqmd_pkg::CODE_W +: qqmd_pkg::CODE_W]);
        qx    = quat_to_fixed(pose[1*qqmd_pkg::CODE_W +: qqmd_pkg::CODE_W]);
        qy    = quat_to_fixed(pose[2*qqmd_pkg::CODE_W +: qqmd_pkg::CODE_W]);
        qz    = quat_to_fixed(pose[3*qqmd_pkg::CODE_W +: qqmd_pkg::CODE_W]);
        unity = longint'(1) <<< (2 * FRAC);
        entry[0] = unity - 2 * (qy * qy + qz * qz);
        entry[1] = 2 * (qx * qy - qw * qz);
        entry[2] = 2 * (qx * qz + qw * qy);
        entry[3] = 2 * (qx * qy + qw * qz);
        entry[4] = unity - 2 * (qx * qx + qz * qz);
        entry[5] = 2 * (qy * qz - qw * qx);
        entry[6] = 2 * (qx * qz - qw * qy);
        entry[7] = 2 * (qy * qz + qw * qx);
        entry[8] = unity - 2 * (qx * qx + qy * qy);
        mat = '0;
        for (int i = 0; i < qqmd_pkg::N_ROT; i++)
            mat[i*qqmd_pkg::ROT_W +: qqmd_pkg::ROT_W] = round_entry(entry[i]);
        // Translation is the code with its bias removed, modulo 2^16.
        for (int j = 0; j < qqmd_pkg::N_TRANS; j++)
            mat[qqmd_pkg::N_ROT*qqmd_pkg::ROT_W + j*qqmd_pkg::TR_W +: qqmd_pkg::TR_W] =
                pose[(qqmd_pkg::N_QUAT + j)*qqmd_pkg::CODE_W +: qqmd_pkg::CODE_W]
                - qqmd_pkg::T_BIAS;
        return mat;
    endfunction

    function void note_pose(pose_beat_t pose);
        matrices_due.push_back(decode_pose(pose));
    endfunction

    function void check_matrix(matrix_beat_t got);
        matrix_beat_t want;
        int           base;
        if (matrices_due.size() == 0)
        begin
            $display("%0t: output beat with nothing expected, data %h", $time, got);
            fails++;
            return;
        end
        want = matrices_due.pop_front();
        for (int i = 0; i < qqmd_pkg::N_ROT; i++)
        begin
            base = i * qqmd_pkg::ROT_W;
            if (got[base +: qqmd_pkg::ROT_W] !== want[base +: qqmd_pkg::ROT_W])
            begin
                $display("%0t: rot_%0d%0d expected %0d got %0d", $time, i / 3, i % 3,
                         $signed(want[base +: qqmd_pkg::ROT_W]),
                         $signed(got[base +: qqmd_pkg::ROT_W]));
                fails++;
            end
        end
        for (int j = 0; j < qqmd_pkg::N_TRANS; j++)
        begin
            base = qqmd_pkg::N_ROT * qqmd_pkg::ROT_W + j * qqmd_pkg::TR_W;
            if (got[base +: qqmd_pkg::TR_W] !== want[base +: qqmd_pkg::TR_W])
            begin
                $display("%0t: trans_%0d expected %0d got %0d", $time, j,
                         $signed(want[base +: qqmd_pkg::TR_W]),
                         $signed(got[base +: qqmd_pkg::TR_W]));
                fails++;
            end
        end
        if (got[qqmd_pkg::OUT_DATA_W-1:PAD_LO] !== want[qqmd_pkg::OUT_DATA_W-1:PAD_LO])
        begin
            $display("%0t: pad bits expected %b got %b", $time,
                     want[qqmd_pkg::OUT_DATA_W-1:PAD_LO], got[qqmd_pkg::OUT_DATA_W-1:PAD_LO]);
            fails++;
        end
    endfunction
endclass

module tb_top;

    localparam int RANDOM_POSES = 1950;
    // Stop all idling once this many beats have passed on a side.
    localparam int QUIET_FROM   = 1750;
    // Long sink stall: start after this many output beats, hold this many cycles.
    localparam int LONG_HOLD_AT = 400;
    localparam int LONG_HOLD    = 64;
    // Source drains the pipe completely before sending this pose.
    localparam int DRAIN_AT     = 1000;
    localparam int LATENCY      = 7;
    localparam int STALL_LIMIT  = 2000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    pose_beat_t   s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    matrix_beat_t m_tdata;

    pose_scoreboard sb = new();
    int             poses_sent;
    int             matrices_seen;

    quantized_quat_to_matrix_decode #(
        .FRAC_BITS(qqmd_pkg::FRAC_BITS_DEF)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Idle burst length for a side that has moved `progress` beats: segments of 200
    // beats alternate between no idling, rare bursts and frequent bursts.
    function automatic int gap_len(int progress);
        int chance;
        if (progress >= QUIET_FROM)
            return 0;
        case ((progress / 200) % 3)
            0: chance = 0;
            1: chance = 8;
            default: chance = 3;
        endcase
        if (chance == 0 || $urandom_range(0, chance - 1) != 0)
            return 0;
        return $urandom_range(1, 9);
    endfunction

    function automatic pose_beat_t random_bits();
        return pose_beat_t'({$urandom(), $urandom(), $urandom(), $urandom()});
    endfunction

    function automatic pose_beat_t make_pose(
        logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z,
        logic [15:0] tx, logic [15:0] ty, logic [15:0] tz);
        return {tz, ty, tx, z, y, x, w};
    endfunction

    // Half full-range codes; a third inside the unit range, the rest at the edge codes.
    function automatic pose_beat_t random_pose();
        pose_beat_t pose;
        int         kind;
        pose = random_bits();
        kind = $urandom_range(0, 5);
        for (int k = 0; k < qqmd_pkg::N_QUAT; k++)
        begin
            if (kind == 3 || kind == 4)
                pose[k*qqmd_pkg::CODE_W +: qqmd_pkg::CODE_W] =
                    16'($urandom_range(16383, 49149));
            else if (kind == 5)
            begin
                case ($urandom_range(0, 7))
                    0: pose[k*qqmd_pkg::CODE_W +: qqmd_pkg::CODE_W] = 16'd0;
                    1: pose[k*qqmd_pkg::CODE_W +: qqmd_pkg::CODE_W] = 16'd1;
                    2: pose[k*qqmd_pkg::CODE_W +: qqmd_pkg::CODE_W] = 16'd16383;
                    3: pose[k*qqmd_pkg::CODE_W +: qqmd_pkg::CODE_W] = 16'd32765;
                    4: pose[k*qqmd_pkg::CODE_W +: qqmd_pkg::CODE_W] = 16'd32766;
                    5: pose[k*qqmd_pkg::CODE_W +: qqmd_pkg::CODE_W] = 16'd32767;
                    6: pose[k*qqmd_pkg::CODE_W +: qqmd_pkg::CODE_W] = 16'd49149;
                    default: pose[k*qqmd_pkg::CODE_W +: qqmd_pkg::CODE_W] = 16'd65535;
                endcase
            end
        end
        return pose;
    endfunction

    // Offer one pose and hold it until the block takes it; record it on acceptance.
    task automatic send_pose(input pose_beat_t pose);
        s_tvalid <= 1'b1;
        s_tdata  <= pose;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_pose(pose);
        poses_sent++;
    endtask

    // Drop valid for a number of cycles; scramble data meanwhile since it must be ignored.
    task automatic source_idle(input int cycles);
        s_tvalid <= 1'b0;
        s_tdata  <= random_bits();
        repeat (cycles)
            @(posedge clk);
    endtask

    // Send a pose, then idle for a random burst unless the long sink stall is near.
    task automatic send_and_gap(input pose_beat_t pose);
        int gap;
        send_pose(pose);
        gap = gap_len(poses_sent);
        if (poses_sent >= LONG_HOLD_AT - 20 && poses_sent < LONG_HOLD_AT + LONG_HOLD + 60)
            gap = 0;
        if (gap > 0)
            source_idle(gap);
    endtask

    // Sink: check every accepted output beat and pick the next cycle's tready.
    initial
    begin : result_sink
        int  hold_left;
        bit  long_done;
        int  gap;
        hold_left = 0;
        long_done = 1'b0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                sb.check_matrix(m_tdata);
                matrices_seen++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!long_done && matrices_seen >= LONG_HOLD_AT)
            begin
                // Hold off long enough for the pipe to fill and stall the source.
                long_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                gap = gap_len(matrices_seen);
                if (gap > 0)
                begin
                    hold_left = gap - 1;
                    m_tready <= 1'b0;
                end
                else
                    m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when neither side moves a beat for too long.
    initial
    begin : stall_watch
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("** quantized_quat_to_matrix_decode: FAILED **");
        $finish;
    end

    initial
    begin : pose_source
        poses_sent    = 0;
        matrices_seen = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed poses: zero, identity and unit axes, code extremes, smallest steps.
        send_and_gap(make_pose(16'd32766, 16'd32766, 16'd32766, 16'd32766,
                               16'd32768, 16'd32768, 16'd32768));
        send_and_gap(make_pose(16'd49149, 16'd32766, 16'd32766, 16'd32766,
                               16'd0, 16'd65535, 16'd32767));
        send_and_gap(make_pose(16'd16383, 16'd32766, 16'd32766, 16'd32766,
                               16'd65535, 16'd0, 16'd1));
        send_and_gap(make_pose(16'd32766, 16'd49149, 16'd32766, 16'd32766,
                               16'd32767, 16'd32769, 16'd0));
        send_and_gap(make_pose(16'd32766, 16'd32766, 16'd49149, 16'd32766,
                               16'd1, 16'd65534, 16'd32768));
        send_and_gap(make_pose(16'd32766, 16'd32766, 16'd32766, 16'd49149,
                               16'd43690, 16'd21845, 16'd65535));
        send_and_gap(make_pose(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_and_gap(make_pose(16'd65535, 16'd65535, 16'd65535, 16'd65535,
                               16'd65535, 16'd65535, 16'd65535));
        send_and_gap(make_pose(16'd0, 16'd65535, 16'd0, 16'd65535,
                               16'd32768, 16'd0, 16'd65535));
        send_and_gap(make_pose(16'd65535, 16'd0, 16'd65535, 16'd0,
                               16'd21845, 16'd43690, 16'd32767));
        send_and_gap(make_pose(16'd1, 16'd65534, 16'd65535, 16'd0,
                               16'd12345, 16'd54321, 16'd4096));
        send_and_gap(make_pose(16'd32765, 16'd32767, 16'd32765, 16'd32767,
                               16'd32768, 16'd32767, 16'd32769));
        send_and_gap(make_pose(16'd40958, 16'd40958, 16'd40958, 16'd40958,
                               16'd100, 16'd200, 16'd300));
        send_and_gap(make_pose(16'd40958, 16'd24574, 16'd40958, 16'd24574,
                               16'd65000, 16'd500, 16'd32000));
        send_and_gap(make_pose(16'd16383, 16'd16383, 16'd16383, 16'd16383,
                               16'd4660, 16'd22136, 16'd39612));
        send_and_gap(make_pose(16'd49149, 16'd49149, 16'd49149, 16'd49149,
                               16'd57005, 16'd48879, 16'd51966));

        // Random poses, with one full drain partway through.
        for (int n = 0; n < RANDOM_POSES; n++)
        begin
            if (poses_sent == DRAIN_AT)
            begin
                s_tvalid <= 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            send_and_gap(random_pose());
        end
        s_tvalid <= 1'b0;

        // Wait for the last matrix, then a little longer to catch stray beats.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3 * LATENCY)
            @(posedge clk);
        if (sb.fails == 0)
            $display("** quantized_quat_to_matrix_decode: PASSED **");
        else
            $display("** quantized_quat_to_matrix_decode: FAILED **");
        $finish;
    end
endmodule

/* files.f */
rtl/core/qqmd_pkg.sv
rtl/core/qqmd_qfix.sv
rtl/core/qqmd_round.sv
rtl/core/quantized_quat_to_matrix_decode.sv
bench/tb_top.sv
